>>> rtl/assert_macros.svh
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication
`define ASSERT_NOW(label, ante, cons, msg) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication
`define ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |=> (cons)) \
        else $error(msg);

`endif

>>> rtl/swarq_pkg.sv
package swarq_pkg;

    localparam int LEN_W      = 32;
    localparam int FLEN_W     = 16;
    localparam int RETRY_W    = 8;
    localparam int TRY_W      = 9;
    localparam int CNT_W      = 32;
    localparam int CFG_DATA_W = 16;
    localparam int CFG_IDX_W  = 2;

    localparam logic [FLEN_W-1:0]  PAYLOAD_LIMIT_RESET = 16'd1024;
    localparam logic [RETRY_W-1:0] RETRY_LIMIT_RESET   = 8'd10;
    localparam logic [TRY_W-1:0]   TRY_MAX             = 9'd511;
    localparam logic [CNT_W-1:0]   CNT_MAX             = 32'hFFFF_FFFF;

    typedef enum logic [1:0] {
        OP_START   = 2'd0,
        OP_ACK     = 2'd1,
        OP_TIMEOUT = 2'd2
    } op_t;

    typedef enum logic [1:0] {
        KIND_INITIAL = 2'd0,
        KIND_DATA    = 2'd1,
        KIND_FINAL   = 2'd2
    } kind_t;

    typedef enum logic [1:0] {
        END_NONE    = 2'd0,
        END_DONE    = 2'd1,
        END_GAVE_UP = 2'd2
    } end_t;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_PAYLOAD_LIMIT   = 2'd0,
        CFG_RETRY_LIMIT     = 2'd1,
        CFG_INITIAL_SEQ_BIT = 2'd2
    } cfg_idx_t;

    typedef struct packed {
        op_t              operation;
        logic [LEN_W-1:0] transfer_length;
        logic             ack_bit;
    } in_word_t;

    typedef struct packed {
        logic              send_frame;
        kind_t             frame_kind;
        logic              frame_seq_bit;
        logic [FLEN_W-1:0] frame_length;
        end_t              transfer_end;
        logic [CNT_W-1:0]  frames_sent_total;
        logic [CNT_W-1:0]  frames_needed_total;
    } out_word_t;

    typedef struct packed {
        logic [FLEN_W-1:0]  payload_limit;
        logic [RETRY_W-1:0] retry_limit;
        logic               initial_seq_bit;
    } cfg_t;

    function automatic logic [CNT_W-1:0] sat_inc(input logic [CNT_W-1:0] v);
        return (v == CNT_MAX) ? v : v + 1'b1;
    endfunction

endpackage

>>> rtl/stop_and_wait_arq_sender_unit.sv
// Alternating-bit stop-and-wait sender. Each input word (start, acknowledgement or timeout)
// gives exactly one result word, and one word can be taken every cycle unless the result side
// holds it off: the word passes an input register, then one pass through the frame logic into
// the result register. s_ready drops only while both registers are full and m_ready is low.
// Configuration writes are taken at once (cfg_ready is always high) and should only be made
// while no word is in flight; writes to an index past the register list are ignored.
`include "assert_macros.svh"

module stop_and_wait_arq_sender_unit (
    input  logic                                  aclk,
    input  logic                                  aresetn,
    input  logic                                  s_valid,
    output logic                                  s_ready,
    input  swarq_pkg::in_word_t                   s_data,
    output logic                                  m_valid,
    input  logic                                  m_ready,
    output swarq_pkg::out_word_t                  m_data,
    input  logic                                  cfg_valid,
    output logic                                  cfg_ready,
    input  logic [swarq_pkg::CFG_IDX_W-1:0]       cfg_index,
    input  logic [swarq_pkg::CFG_DATA_W-1:0]      cfg_data
);

    logic                  in_valid_reg, in_valid_next;
    swarq_pkg::in_word_t   in_data_reg;
    logic                  out_valid_reg, out_valid_next;
    swarq_pkg::out_word_t  out_data_reg;
    swarq_pkg::cfg_t       cfg_reg;
    swarq_pkg::out_word_t  res;
    logic                  advance, fire, s_accept;

    assign advance   = !out_valid_reg || m_ready;
    assign fire      = in_valid_reg && advance;
    assign s_ready   = !in_valid_reg || advance;
    assign s_accept  = s_valid && s_ready;
    assign cfg_ready = 1'b1;
    assign m_valid   = out_valid_reg;
    assign m_data    = out_data_reg;

    always_comb begin
        in_valid_next  = s_accept ? 1'b1 : (advance ? 1'b0 : in_valid_reg);
        out_valid_next = advance ? in_valid_reg : out_valid_reg;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end else begin
            in_valid_reg  <= in_valid_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_accept) begin
            in_data_reg <= s_data;
        end
        if (fire) begin
            out_data_reg <= res;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.payload_limit   <= swarq_pkg::PAYLOAD_LIMIT_RESET;
            cfg_reg.retry_limit     <= swarq_pkg::RETRY_LIMIT_RESET;
            cfg_reg.initial_seq_bit <= 1'b0;
        end else if (cfg_valid) begin
            unique case (cfg_index)
                swarq_pkg::CFG_PAYLOAD_LIMIT:   cfg_reg.payload_limit <= cfg_data;
                swarq_pkg::CFG_RETRY_LIMIT:     cfg_reg.retry_limit <= cfg_data[swarq_pkg::RETRY_W-1:0];
                swarq_pkg::CFG_INITIAL_SEQ_BIT: cfg_reg.initial_seq_bit <= cfg_data[0];
                default: ;
            endcase
        end
    end

    swarq_engine u_engine (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .evt_valid (fire),
        .evt       (in_data_reg),
        .cfg       (cfg_reg),
        .res       (res)
    );

    `ASSERT_NOW(a_stall_only_when_full, !s_ready, in_valid_reg && out_valid_reg && !m_ready, "input stalled with room")
    `ASSERT_NEXT(a_word_reaches_result, fire, out_valid_reg, "processed word lost")
    `ASSERT_NEXT(a_held_word_kept, in_valid_reg && !advance, in_valid_reg && $stable(in_data_reg), "waiting word dropped")

endmodule

>>> rtl/swarq_engine.sv
`include "assert_macros.svh"

module swarq_engine (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                evt_valid,
    input  swarq_pkg::in_word_t evt,
    input  swarq_pkg::cfg_t     cfg,
    output swarq_pkg::out_word_t res
);

    logic                           busy_reg, busy_next;
    logic [swarq_pkg::LEN_W-1:0]    bytes_left_reg, bytes_left_next;
    logic                           first_reg, first_next;
    logic                           last_reg, last_next;
    logic                           seq_reg, seq_next;
    logic [swarq_pkg::TRY_W-1:0]    try_reg, try_next;
    swarq_pkg::kind_t               kind_reg, kind_next;
    logic [swarq_pkg::FLEN_W-1:0]   flen_reg, flen_next;
    logic [swarq_pkg::CNT_W-1:0]    sent_reg, sent_next;
    logic [swarq_pkg::CNT_W-1:0]    needed_reg, needed_next;

    logic                           start_go, ack_go, resend, build, sending, big, gave_up;
    logic [swarq_pkg::FLEN_W-1:0]   lim;
    logic [swarq_pkg::LEN_W-1:0]    src;
    logic [swarq_pkg::TRY_W-1:0]    try_base;
    logic [swarq_pkg::CNT_W-1:0]    sent_base, needed_base;

    always_comb begin
        start_go = (evt.operation == swarq_pkg::OP_START) && !busy_reg;
        ack_go   = (evt.operation == swarq_pkg::OP_ACK) && busy_reg && (evt.ack_bit == seq_reg);
        resend   = ((evt.operation == swarq_pkg::OP_ACK) || (evt.operation == swarq_pkg::OP_TIMEOUT))
                   && busy_reg && !ack_go;
        build    = start_go || (ack_go && !last_reg);
        sending  = build || resend;

        // zero limit acts as one byte
        lim = (cfg.payload_limit == '0) ? swarq_pkg::FLEN_W'(1) : cfg.payload_limit;
        src = start_go ? evt.transfer_length : bytes_left_reg;
        big = src > {{(swarq_pkg::LEN_W-swarq_pkg::FLEN_W){1'b0}}, lim};

        first_next = start_go ? 1'b1 : (ack_go ? 1'b0 : first_reg);
        seq_next   = start_go ? cfg.initial_seq_bit : (ack_go ? ~seq_reg : seq_reg);

        kind_next       = kind_reg;
        flen_next       = flen_reg;
        last_next       = last_reg;
        bytes_left_next = bytes_left_reg;
        try_base        = try_reg;
        if (build) begin
            try_base = '0;
            if (big) begin
                kind_next       = first_next ? swarq_pkg::KIND_INITIAL : swarq_pkg::KIND_DATA;
                flen_next       = lim;
                last_next       = 1'b0;
                bytes_left_next = src - {{(swarq_pkg::LEN_W-swarq_pkg::FLEN_W){1'b0}}, lim};
            end else begin
                kind_next       = swarq_pkg::KIND_FINAL;
                flen_next       = src[swarq_pkg::FLEN_W-1:0];
                last_next       = 1'b1;
                bytes_left_next = '0;
            end
        end

        sent_base   = start_go ? '0 : sent_reg;
        needed_base = start_go ? '0 : needed_reg;
        try_next    = try_base;
        sent_next   = sent_base;
        needed_next = needed_base;
        gave_up     = 1'b0;
        if (sending) begin
            try_next  = (try_base < swarq_pkg::TRY_MAX) ? try_base + 1'b1 : try_base;
            sent_next = swarq_pkg::sat_inc(sent_base);
            if (try_next == swarq_pkg::TRY_W'(1)) begin
                needed_next = swarq_pkg::sat_inc(needed_base);
            end
            gave_up = last_next && (try_next > {1'b0, cfg.retry_limit});
        end

        busy_next = busy_reg;
        if (start_go) begin
            busy_next = 1'b1;
        end
        if (ack_go && last_reg) begin
            busy_next = 1'b0;
        end
        if (gave_up) begin
            busy_next = 1'b0;
        end

        res.send_frame          = sending;
        res.frame_kind          = sending ? kind_next : swarq_pkg::KIND_INITIAL;
        res.frame_seq_bit       = sending & seq_next;
        res.frame_length        = sending ? flen_next : '0;
        res.frames_sent_total   = sent_next;
        res.frames_needed_total = needed_next;
        if (gave_up) begin
            res.transfer_end = swarq_pkg::END_GAVE_UP;
        end else if (ack_go && last_reg) begin
            res.transfer_end = swarq_pkg::END_DONE;
        end else begin
            res.transfer_end = swarq_pkg::END_NONE;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg       <= 1'b0;
            bytes_left_reg <= '0;
            first_reg      <= 1'b1;
            last_reg       <= 1'b0;
            seq_reg        <= 1'b0;
            try_reg        <= '0;
            kind_reg       <= swarq_pkg::KIND_INITIAL;
            flen_reg       <= '0;
            sent_reg       <= '0;
            needed_reg     <= '0;
        end else if (evt_valid) begin
            busy_reg       <= busy_next;
            bytes_left_reg <= bytes_left_next;
            first_reg      <= first_next;
            last_reg       <= last_next;
            seq_reg        <= seq_next;
            try_reg        <= try_next;
            kind_reg       <= kind_next;
            flen_reg       <= flen_next;
            sent_reg       <= sent_next;
            needed_reg     <= needed_next;
        end
    end

    `ASSERT_NOW(a_give_up_on_final, evt_valid && (res.transfer_end == swarq_pkg::END_GAVE_UP), res.send_frame && last_next && (res.frame_kind == swarq_pkg::KIND_FINAL), "give up outside a final frame send")
    `ASSERT_NEXT(a_idle_holds_state, !evt_valid, $stable(busy_reg) && $stable(sent_reg) && $stable(seq_reg), "state moved without a word")
    `ASSERT_NOW(a_send_counts, evt_valid && res.send_frame, (res.frames_sent_total != '0) && (try_next != '0), "send not counted")

endmodule

>>> verif/tb_stop_and_wait_arq_sender_unit.sv
`timescale 1ns / 100ps

module tb_stop_and_wait_arq_sender_unit;

    localparam logic [1:0] OP_RESERVED = 2'd3;
    localparam logic [1:0] CFG_SPARE   = 2'd3;
    localparam int         HOLD_CYCLES = 60;

    typedef struct packed {
        bit                   reg_set;
        logic [15:0]          pl;
        logic [7:0]           rl;
        logic                 sb;
        swarq_pkg::in_word_t  stim;
        bit                   typed_in;
        swarq_pkg::out_word_t want;
    } script_row_t;

    logic                            aclk;
    logic                            aresetn;
    logic                            s_valid;
    logic                            s_ready;
    swarq_pkg::in_word_t             s_data;
    logic                            m_valid;
    logic                            m_ready;
    swarq_pkg::out_word_t            m_data;
    logic                            cfg_valid;
    logic                            cfg_ready;
    logic [swarq_pkg::CFG_IDX_W-1:0]  cfg_index;
    logic [swarq_pkg::CFG_DATA_W-1:0] cfg_data;

    // sender model state
    logic             tx_active = 1'b0;
    logic [31:0]      bytes_rem = '0;
    logic             on_first  = 1'b1;
    logic             on_last   = 1'b0;
    logic             cur_seq   = 1'b0;
    logic [8:0]       tries     = '0;
    swarq_pkg::kind_t cur_kind  = swarq_pkg::KIND_INITIAL;
    logic [15:0]      cur_len   = '0;
    logic [31:0]      sends     = '0;
    logic [31:0]      firsts    = '0;
    logic [15:0]      lim_payload = swarq_pkg::PAYLOAD_LIMIT_RESET;
    logic [7:0]       lim_retry   = swarq_pkg::RETRY_LIMIT_RESET;
    logic             seq_start   = 1'b0;

    swarq_pkg::out_word_t pending_results[$];
    script_row_t          script[$];
    swarq_pkg::out_word_t head;
    int                   errors;
    int                   words_in;
    int                   words_acted;
    int                   n_done;
    int                   n_gave_up;
    int                   n_sends_seen;
    int                   in_stalls;
    bit                   calm;
    int                   hold_asks;
    int                   hold_taken;
    int                   hold_left;

    stop_and_wait_arq_sender_unit i_dut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_valid   (s_valid),
        .s_ready   (s_ready),
        .s_data    (s_data),
        .m_valid   (m_valid),
        .m_ready   (m_ready),
        .m_data    (m_data),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    initial begin
        aclk = 1'b0;
        forever #2 aclk = ~aclk;
    end

    initial begin
        #8_000_000;
        $display("TEST FAILED");
        $finish;
    end

    function automatic void load_frame();
        logic [31:0] cap;
        cap = (lim_payload == 16'd0) ? 32'd1 : {16'd0, lim_payload};
        if (bytes_rem > cap) begin
            cur_kind  = on_first ? swarq_pkg::KIND_INITIAL : swarq_pkg::KIND_DATA;
            cur_len   = cap[15:0];
            bytes_rem = bytes_rem - cap;
        end else begin
            cur_kind  = swarq_pkg::KIND_FINAL;
            cur_len   = bytes_rem[15:0];
            on_last   = 1'b1;
            bytes_rem = '0;
        end
        tries = '0;
    endfunction

    function automatic swarq_pkg::out_word_t predict_sender_response(
        input swarq_pkg::in_word_t w);
        swarq_pkg::out_word_t r;
        logic                 fire;
        r    = '0;
        fire = 1'b0;
        if (w.operation == swarq_pkg::OP_START && !tx_active) begin
            tx_active = 1'b1;
            bytes_rem = w.transfer_length;
            on_first  = 1'b1;
            on_last   = 1'b0;
            cur_seq   = seq_start;
            sends     = '0;
            firsts    = '0;
            load_frame();
            fire = 1'b1;
        end else if (w.operation == swarq_pkg::OP_ACK && tx_active && w.ack_bit == cur_seq) begin
            on_first = 1'b0;
            cur_seq  = ~cur_seq;
            if (on_last) begin
                tx_active      = 1'b0;
                r.transfer_end = swarq_pkg::END_DONE;
            end else begin
                load_frame();
                fire = 1'b1;
            end
        end else if ((w.operation == swarq_pkg::OP_ACK || w.operation == swarq_pkg::OP_TIMEOUT)
                     && tx_active) begin
            fire = 1'b1;
        end
        if (fire) begin
            r.send_frame    = 1'b1;
            r.frame_kind    = cur_kind;
            r.frame_seq_bit = cur_seq;
            r.frame_length  = cur_len;
            if (tries != swarq_pkg::TRY_MAX) tries = tries + 1'b1;
            if (sends != swarq_pkg::CNT_MAX) sends = sends + 1'b1;
            if (tries == 9'd1 && firsts != swarq_pkg::CNT_MAX) firsts = firsts + 1'b1;
            if (on_last && tries > {1'b0, lim_retry}) begin
                tx_active      = 1'b0;
                r.transfer_end = swarq_pkg::END_GAVE_UP;
            end
        end
        r.frames_sent_total   = sends;
        r.frames_needed_total = firsts;
        return r;
    endfunction

    function automatic swarq_pkg::in_word_t mk_word(input logic [1:0] op, input logic [31:0] len,
                                                    input logic ack);
        swarq_pkg::in_word_t w;
        w.operation       = swarq_pkg::op_t'(op);
        w.transfer_length = len;
        w.ack_bit         = ack;
        return w;
    endfunction

    function automatic swarq_pkg::out_word_t res(input logic send, input swarq_pkg::kind_t kind,
                                                 input logic seq, input logic [15:0] flen,
                                                 input swarq_pkg::end_t tend,
                                                 input logic [31:0] sent,
                                                 input logic [31:0] needed);
        swarq_pkg::out_word_t r;
        r.send_frame          = send;
        r.frame_kind          = kind;
        r.frame_seq_bit       = seq;
        r.frame_length        = flen;
        r.transfer_end        = tend;
        r.frames_sent_total   = sent;
        r.frames_needed_total = needed;
        return r;
    endfunction

    function automatic void add_row(input logic [1:0] op, input logic [31:0] len,
                                    input logic ack, input bit typed_in,
                                    input swarq_pkg::out_word_t want);
        script_row_t r;
        r          = '0;
        r.stim     = mk_word(op, len, ack);
        r.typed_in = typed_in;
        r.want     = want;
        script     = {script, r};
    endfunction

    function automatic void add_regs(input logic [15:0] pl, input logic [7:0] rl,
                                     input logic sb);
        script_row_t r;
        r         = '0;
        r.reg_set = 1'b1;
        r.pl      = pl;
        r.rl      = rl;
        r.sb      = sb;
        script    = {script, r};
    endfunction

    task automatic cmp_field(input string name, input logic [31:0] exp_v,
                             input logic [31:0] act_v);
        if (act_v !== exp_v) begin
            $error("%s: expected %0d, got %0d", name, exp_v, act_v);
            errors++;
        end
    endtask

    task automatic put_word(input swarq_pkg::in_word_t w, input bit typed_in,
                            input swarq_pkg::out_word_t want);
        swarq_pkg::out_word_t got;
        bit                   acts;
        if (!calm && $urandom_range(0, 99) < 7) begin
            s_valid <= 1'b0;
            @(negedge aclk);
        end
        s_valid <= 1'b1;
        s_data  <= w;
        @(posedge aclk);
        while (!s_ready) @(posedge aclk);
        @(negedge aclk);
        acts = (w.operation == swarq_pkg::OP_START) ? !tx_active :
               ((w.operation == swarq_pkg::OP_ACK || w.operation == swarq_pkg::OP_TIMEOUT)
                && tx_active);
        got = predict_sender_response(w);
        pending_results = {pending_results, (typed_in ? want : got)};
        words_in++;
        if (acts) words_acted++;
    endtask

    task automatic push_ack();
        put_word(mk_word(swarq_pkg::OP_ACK, $urandom, cur_seq), 1'b0, '0);
    endtask

    task automatic push_fault();
        if ($urandom_range(0, 1))
            put_word(mk_word(swarq_pkg::OP_TIMEOUT, $urandom, 1'($urandom_range(0, 1))),
                     1'b0, '0);
        else
            put_word(mk_word(swarq_pkg::OP_ACK, $urandom, ~cur_seq), 1'b0, '0);
    endtask

    task automatic wait_drain();
        s_valid <= 1'b0;
        while (pending_results.size() != 0) @(posedge aclk);
        repeat (4) @(posedge aclk);
        @(negedge aclk);
    endtask

    task automatic configure(input logic [15:0] pl, input logic [7:0] rl, input logic sb);
        logic [1:0]  idx [4];
        logic [15:0] val [4];
        logic [31:0] junk;
        int          i;
        wait_drain();
        junk   = $urandom;
        idx[0] = swarq_pkg::CFG_PAYLOAD_LIMIT;
        idx[1] = swarq_pkg::CFG_RETRY_LIMIT;
        idx[2] = swarq_pkg::CFG_INITIAL_SEQ_BIT;
        idx[3] = CFG_SPARE;
        val[0] = pl;
        val[1] = {junk[15:8], rl};
        val[2] = {junk[31:17], sb};
        val[3] = junk[15:0];
        cfg_valid <= 1'b1;
        for (i = 0; i < 4; i++) begin
            cfg_index <= idx[i];
            cfg_data  <= val[i];
            @(posedge aclk);
            while (!cfg_ready) @(posedge aclk);
            @(negedge aclk);
            case (idx[i])
                swarq_pkg::CFG_PAYLOAD_LIMIT:   lim_payload = val[i];
                swarq_pkg::CFG_RETRY_LIMIT:     lim_retry   = val[i][7:0];
                swarq_pkg::CFG_INITIAL_SEQ_BIT: seq_start   = val[i][0];
                default: ;
            endcase
        end
        cfg_valid <= 1'b0;
    endtask

    // result side: random back-pressure plus an occasional long hold-off
    initial begin
        m_ready    = 1'b0;
        hold_left  = 0;
        hold_taken = 0;
        forever begin
            @(negedge aclk);
            if (hold_taken != hold_asks && hold_left == 0) begin
                hold_taken = hold_asks;
                hold_left  = HOLD_CYCLES;
            end
            if (hold_left != 0) begin
                hold_left--;
                m_ready <= 1'b0;
            end else begin
                m_ready <= calm || ($urandom_range(0, 99) >= 7);
            end
        end
    end

    always @(posedge aclk) begin
        if (aresetn) begin
            if (s_valid && !s_ready) in_stalls++;
            if (m_valid && m_ready) begin
                if (pending_results.size() == 0) begin
                    $error("result word with nothing expected");
                    errors++;
                end else begin
                    head = pending_results.pop_front();
                    cmp_field("send_frame", head.send_frame, m_data.send_frame);
                    cmp_field("frame_kind", head.frame_kind, m_data.frame_kind);
                    cmp_field("frame_seq_bit", head.frame_seq_bit, m_data.frame_seq_bit);
                    cmp_field("frame_length", head.frame_length, m_data.frame_length);
                    cmp_field("transfer_end", head.transfer_end, m_data.transfer_end);
                    cmp_field("frames_sent_total", head.frames_sent_total,
                              m_data.frames_sent_total);
                    cmp_field("frames_needed_total", head.frames_needed_total,
                              m_data.frames_needed_total);
                    if (head.send_frame) n_sends_seen++;
                    if (head.transfer_end == swarq_pkg::END_DONE) n_done++;
                    if (head.transfer_end == swarq_pkg::END_GAVE_UP) n_gave_up++;
                end
            end
        end
    end

    initial begin
        int          phase;
        int unsigned cap;
        int unsigned len;
        int unsigned nfr;
        int          target;
        int          pick;
        logic [31:0] junk;

        aresetn   = 1'b0;
        s_valid   = 1'b0;
        s_data    = '0;
        cfg_valid = 1'b0;
        cfg_index = '0;
        cfg_data  = '0;
        calm      = 1'b0;
        hold_asks = 0;
        repeat (2) @(negedge aclk);
        aresetn <= 1'b1;
        @(negedge aclk);

        // directed script, reset register values first
        add_row(swarq_pkg::OP_ACK,     '1, 1'b1, 1'b1, '0);
        add_row(swarq_pkg::OP_TIMEOUT, '0, 1'b0, 1'b1, '0);
        add_row(OP_RESERVED,           '1, 1'b1, 1'b1, '0);
        add_row(swarq_pkg::OP_START,   '0, 1'b0, 1'b1,
                res(1'b1, swarq_pkg::KIND_FINAL, 1'b0, 16'd0, swarq_pkg::END_NONE, 1, 1));
        add_row(swarq_pkg::OP_START,   '1, 1'b1, 1'b1,
                res(1'b0, swarq_pkg::KIND_INITIAL, 1'b0, 16'd0, swarq_pkg::END_NONE, 1, 1));
        add_row(OP_RESERVED,           32'h5a5a_a5a5, 1'b0, 1'b0, '0);
        add_row(swarq_pkg::OP_ACK,     '0, 1'b1, 1'b0, '0);
        add_row(swarq_pkg::OP_ACK,     '0, 1'b0, 1'b0, '0);
        add_row(swarq_pkg::OP_START,   32'd2049, 1'b0, 1'b0, '0);
        add_row(swarq_pkg::OP_TIMEOUT, '0, 1'b1, 1'b0, '0);
        add_row(swarq_pkg::OP_ACK,     '0, 1'b0, 1'b0, '0);
        add_row(swarq_pkg::OP_ACK,     '0, 1'b1, 1'b0, '0);
        add_row(swarq_pkg::OP_ACK,     '0, 1'b1, 1'b0, '0);
        add_row(swarq_pkg::OP_ACK,     '0, 1'b0, 1'b0, '0);
        // zero payload limit and zero retries
        add_regs(16'd0, 8'd0, 1'b1);
        add_row(swarq_pkg::OP_START,   32'd2, 1'b0, 1'b0, '0);
        add_row(swarq_pkg::OP_ACK,     '0, 1'b1, 1'b0, '0);
        add_row(swarq_pkg::OP_TIMEOUT, '0, 1'b0, 1'b0, '0);
        add_row(swarq_pkg::OP_START,   '0, 1'b0, 1'b1,
                res(1'b1, swarq_pkg::KIND_FINAL, 1'b1, 16'd0, swarq_pkg::END_GAVE_UP, 1, 1));
        // widest frames
        add_regs(16'hffff, 8'hff, 1'b0);
        add_row(swarq_pkg::OP_START,   32'h0001_0000, 1'b0, 1'b0, '0);
        add_row(swarq_pkg::OP_ACK,     '0, 1'b0, 1'b0, '0);
        add_row(swarq_pkg::OP_ACK,     '0, 1'b1, 1'b0, '0);
        add_row(swarq_pkg::OP_START,   32'h0000_ffff, 1'b1, 1'b0, '0);
        add_row(swarq_pkg::OP_ACK,     '0, 1'b0, 1'b0, '0);

        foreach (script[i]) begin
            if (script[i].reg_set)
                configure(script[i].pl, script[i].rl, script[i].sb);
            else
                put_word(script[i].stim, script[i].typed_in, script[i].want);
        end

        // random transfers over a rotating set of register values
        phase = 0;
        while (phase < 6) begin
            junk = $urandom;
            case (phase % 6)
                0: configure(16'($urandom_range(1, 64)), 8'($urandom_range(0, 15)), junk[0]);
                1: configure(16'd0, 8'd0, 1'b1);
                2: configure(16'hffff, 8'hff, 1'b0);
                3: configure(junk[15:0], junk[23:16], junk[24]);
                4: configure(16'd1, 8'd1, junk[0]);
                default: configure(swarq_pkg::PAYLOAD_LIMIT_RESET,
                                   swarq_pkg::RETRY_LIMIT_RESET, 1'b0);
            endcase
            calm = (phase % 6 == 2);
            if (phase % 6 == 3 || phase % 6 == 5) hold_asks++;
            target = words_acted + 60;
            while (words_acted < target) begin
                if ($urandom_range(0, 99) < 20) begin
                    repeat ($urandom_range(1, 3))
                        put_word(mk_word(2'($urandom_range(1, 3)), $urandom,
                                         1'($urandom_range(0, 1))), 1'b0, '0);
                end
                cap = lim_payload;
                if (cap == 0) cap = 1;
                nfr = $urandom_range(0, 5);
                case ($urandom_range(0, 3))
                    0: len = nfr * cap;
                    1: len = nfr * cap + 1;
                    default: len = $urandom_range(0, (nfr + 1) * cap);
                endcase
                put_word(mk_word(swarq_pkg::OP_START, len, 1'($urandom_range(0, 1))),
                         1'b0, '0);
                while (tx_active) begin
                    pick = $urandom_range(0, 99);
                    if (pick < 62)
                        push_ack();
                    else if (pick < 88)
                        push_fault();
                    else if (pick < 94)
                        put_word(mk_word(swarq_pkg::OP_START, $urandom,
                                         1'($urandom_range(0, 1))), 1'b0, '0);
                    else
                        put_word(mk_word(OP_RESERVED, $urandom, 1'($urandom_range(0, 1))),
                                 1'b0, '0);
                end
            end
            phase++;
        end
        calm = 1'b0;

        // try count saturation on the first frame, then the widest retry limit
        junk = $urandom;
        configure(16'd1, 8'hff, junk[0]);
        hold_asks++;
        put_word(mk_word(swarq_pkg::OP_START, 32'd3, junk[1]), 1'b0, '0);
        repeat (520) push_fault();
        while (!on_last) push_ack();
        while (tx_active) push_fault();

        // largest transfer at the largest frame size, first frames only
        junk = $urandom;
        configure(16'hffff, junk[7:0], junk[8]);
        put_word(mk_word(swarq_pkg::OP_START, '1, junk[9]), 1'b0, '0);
        repeat (8) push_ack();

        wait_drain();
        repeat (10) @(posedge aclk);
        $display("%0d words sent, %0d of them acted on, %0d cycles of input back-pressure",
                 words_in, words_acted, in_stalls);
        $display("%0d frame sends checked, %0d transfers acknowledged, %0d given up",
                 n_sends_seen, n_done, n_gave_up);
        if (errors == 0)
            $display("TEST PASSED");
        else
            $display("TEST FAILED");
        $finish;
    end

endmodule

>>> sim.f
+incdir+rtl
rtl/swarq_pkg.sv
rtl/swarq_engine.sv
rtl/stop_and_wait_arq_sender_unit.sv
verif/tb_stop_and_wait_arq_sender_unit.sv
